[design/uite_pkg.sv]
//------------------------------------------------------------------------------
// uite_pkg
// Types and constants shared by the UART interrupt transfer engine.
//------------------------------------------------------------------------------
`default_nettype none

package uite_pkg;

    // Largest accepted transfer length
    localparam logic [31:0] MAX_LEN = 32'd65535;

    typedef enum logic [2:0] {
        FN_START_SEND = 3'd0,
        FN_START_RECV = 3'd1,
        FN_HW_EVENT   = 3'd2,
        FN_KILL_SEND  = 3'd3,
        FN_KILL_RECV  = 3'd4,
        FN_CLR_FLAGS  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_BUSY    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_READY    = 2'd0,
        ST_ONGOING  = 2'd1,
        ST_COMPLETE = 2'd2
    } t_xfer_state;

    // Enable bits
    localparam logic [5:0] EN_TXEIE  = 6'h01;
    localparam logic [5:0] EN_TCIE   = 6'h02;
    localparam logic [5:0] EN_RXNEIE = 6'h04;
    localparam logic [5:0] EN_IDLEIE = 6'h08;
    localparam logic [5:0] EN_TE     = 6'h10;
    localparam logic [5:0] EN_RE     = 6'h20;

    // Runtime flag bits
    localparam logic [6:0] FL_TXC  = 7'h01;
    localparam logic [6:0] FL_RXC  = 7'h02;
    localparam logic [6:0] FL_IDLE = 7'h04;

    // Hardware status bit positions
    localparam int unsigned HW_TXE  = 0;
    localparam int unsigned HW_TC   = 1;
    localparam int unsigned HW_RXNE = 2;
    localparam int unsigned HW_IDLE = 3;

    // Clear-pending and notify bit positions
    localparam int unsigned CLR_TC   = 0;
    localparam int unsigned CLR_IDLE = 1;
    localparam int unsigned NT_SEND  = 0;
    localparam int unsigned NT_RECV  = 1;
    localparam int unsigned NT_ERR   = 2;

    typedef struct packed {
        t_func       func;
        logic [15:0] length;
        logic [7:0]  hw_status;
        logic [7:0]  rx_byte;
        logic [6:0]  clear_mask;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic        tx_write;
        logic [15:0] tx_index;
        logic        rx_store;
        logic [15:0] rx_index;
        logic [7:0]  rx_data;
        logic [1:0]  clear_pending;
        logic [5:0]  control_bits;
        logic [6:0]  runtime_flags;
        logic [2:0]  notify;
    } t_result;

endpackage

`default_nettype wire

[design/uite_if.sv]
//------------------------------------------------------------------------------
// uite_if
// Valid/ready channels for command items and result items.
//------------------------------------------------------------------------------
`default_nettype none

interface uite_in_if import uite_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [15:0] length;
    logic [7:0]  hw_status;
    logic [7:0]  rx_byte;
    logic [6:0]  clear_mask;

    modport source (
        output valid, func, length, hw_status, rx_byte, clear_mask,
        input  ready
    );
    modport sink (
        input  valid, func, length, hw_status, rx_byte, clear_mask,
        output ready
    );
endinterface

interface uite_out_if import uite_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        tx_write;
    logic [15:0] tx_index;
    logic        rx_store;
    logic [15:0] rx_index;
    logic [7:0]  rx_data;
    logic [1:0]  clear_pending;
    logic [5:0]  control_bits;
    logic [6:0]  runtime_flags;
    logic [2:0]  notify;

    modport source (
        output valid, status, tx_write, tx_index, rx_store, rx_index, rx_data,
               clear_pending, control_bits, runtime_flags, notify,
        input  ready
    );
    modport sink (
        input  valid, status, tx_write, tx_index, rx_store, rx_index, rx_data,
               clear_pending, control_bits, runtime_flags, notify,
        output ready
    );
endinterface

`default_nettype wire

[design/uite_seq.sv]
//------------------------------------------------------------------------------
// uite_seq
// Send/receive sequencer state and the single-pass update for one item.
//------------------------------------------------------------------------------
`default_nettype none

module uite_seq import uite_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire t_item   i_item,
    output t_result      o_result
);

    t_xfer_state r_send_state, n_send_state;
    t_xfer_state r_recv_state, n_recv_state;
    logic [15:0] r_send_rem, n_send_rem;
    logic [15:0] r_send_next, n_send_next;
    logic [15:0] r_recv_rem, n_recv_rem;
    logic [15:0] r_recv_next, n_recv_next;
    logic [5:0]  r_enables, n_enables;
    logic [6:0]  r_flags, n_flags;

    t_result     result;
    logic        len_bad;
    logic        ev_txe, ev_tc, ev_rxne, ev_idle;
    logic [3:0]  ev_errs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_state <= ST_READY;
            r_recv_state <= ST_READY;
            r_send_rem   <= '0;
            r_send_next  <= '0;
            r_recv_rem   <= '0;
            r_recv_next  <= '0;
            r_enables    <= '0;
            r_flags      <= '0;
        end else if (i_fire) begin
            r_send_state <= n_send_state;
            r_recv_state <= n_recv_state;
            r_send_rem   <= n_send_rem;
            r_send_next  <= n_send_next;
            r_recv_rem   <= n_recv_rem;
            r_recv_next  <= n_recv_next;
            r_enables    <= n_enables;
            r_flags      <= n_flags;
        end
    end

    assign len_bad = (i_item.length == 16'd0) || ({16'd0, i_item.length} > MAX_LEN);
    assign ev_txe  = i_item.hw_status[HW_TXE];
    assign ev_tc   = i_item.hw_status[HW_TC];
    assign ev_rxne = i_item.hw_status[HW_RXNE];
    assign ev_idle = i_item.hw_status[HW_IDLE];
    assign ev_errs = i_item.hw_status[7:4];

    always_comb begin
        n_send_state = r_send_state;
        n_recv_state = r_recv_state;
        n_send_rem   = r_send_rem;
        n_send_next  = r_send_next;
        n_recv_rem   = r_recv_rem;
        n_recv_next  = r_recv_next;
        n_enables    = r_enables;
        n_flags      = r_flags;
        result       = '0;
        result.status = STAT_OK;

        unique case (i_item.func)
            FN_START_SEND: begin
                if (len_bad) begin
                    result.status = STAT_INVALID;
                end else if (r_send_state == ST_ONGOING) begin
                    result.status = STAT_BUSY;
                end else begin
                    // first byte goes out right away
                    result.tx_write = 1'b1;
                    result.tx_index = '0;
                    n_send_next     = 16'd1;
                    n_send_rem      = i_item.length - 16'd1;
                    n_send_state    = ST_ONGOING;
                    n_enables       = n_enables | EN_TE | EN_TXEIE;
                end
            end
            FN_START_RECV: begin
                if (len_bad) begin
                    result.status = STAT_INVALID;
                end else if (r_recv_state == ST_ONGOING) begin
                    result.status = STAT_BUSY;
                end else begin
                    n_enables    = n_enables | EN_RXNEIE | EN_RE;
                    n_recv_rem   = i_item.length;
                    n_recv_next  = '0;
                    n_recv_state = ST_ONGOING;
                end
            end
            FN_HW_EVENT: begin
                // interrupt gating uses enables held before the item
                if ((ev_txe || ev_tc) && ((r_enables & (EN_TXEIE | EN_TCIE)) != '0)) begin
                    if (n_send_state == ST_READY) begin
                        result.clear_pending[CLR_TC] = 1'b1;
                        n_enables = n_enables & ~(EN_TCIE | EN_TXEIE);
                    end
                    if (ev_txe && n_send_state == ST_ONGOING) begin
                        if (n_send_rem != '0) begin
                            n_enables       = n_enables & ~EN_TCIE;
                            result.tx_write = 1'b1;
                            result.tx_index = n_send_next;
                            n_send_next     = n_send_next + 16'd1;
                            n_send_rem      = n_send_rem - 16'd1;
                        end else begin
                            n_enables    = (n_enables & ~EN_TXEIE) | EN_TCIE;
                            n_send_state = ST_COMPLETE;
                        end
                    end
                    if (ev_tc && n_send_state == ST_COMPLETE) begin
                        result.clear_pending[CLR_TC] = 1'b1;
                        n_enables = n_enables & ~(EN_TCIE | EN_TXEIE);
                        n_flags   = n_flags | FL_TXC;
                        result.notify[NT_SEND] = 1'b1;
                    end
                end

                if (ev_rxne && ((r_enables & EN_RXNEIE) != '0)
                        && n_recv_state == ST_ONGOING) begin
                    n_enables = n_enables | EN_IDLEIE;
                    result.clear_pending[CLR_IDLE] = 1'b1;
                    result.rx_store = 1'b1;
                    result.rx_index = n_recv_next;
                    result.rx_data  = i_item.rx_byte;
                    n_recv_next     = n_recv_next + 16'd1;
                    n_recv_rem      = n_recv_rem - 16'd1;
                    if (n_recv_rem == '0) begin
                        n_enables    = n_enables & ~(EN_IDLEIE | EN_RE);
                        n_recv_state = ST_COMPLETE;
                        n_flags      = n_flags | FL_RXC;
                        result.notify[NT_RECV] = 1'b1;
                    end
                end
                // line idle aborts an ongoing receive
                if (ev_idle && ((r_enables & EN_IDLEIE) != '0)
                        && n_recv_state == ST_ONGOING) begin
                    n_enables    = n_enables & ~(EN_IDLEIE | EN_RE);
                    result.clear_pending[CLR_IDLE] = 1'b1;
                    n_recv_state = ST_COMPLETE;
                    n_flags      = n_flags | FL_IDLE;
                    result.notify[NT_RECV] = 1'b1;
                end

                if (ev_errs != '0) begin
                    n_flags = n_flags | {ev_errs, 3'b000};
                    result.notify[NT_ERR] = 1'b1;
                end
            end
            FN_KILL_SEND: begin
                n_enables    = n_enables & ~(EN_TCIE | EN_TXEIE);
                n_send_state = ST_READY;
                n_send_rem   = '0;
                n_send_next  = '0;
            end
            FN_KILL_RECV: begin
                n_enables    = n_enables & ~EN_RXNEIE;
                n_recv_state = ST_READY;
                n_recv_rem   = '0;
                n_recv_next  = '0;
            end
            FN_CLR_FLAGS: begin
                n_flags = n_flags & ~i_item.clear_mask;
            end
            default: begin
                // unused selector codes: no change
            end
        endcase

        result.control_bits  = n_enables;
        result.runtime_flags = n_flags;
    end

    assign o_result = result;

endmodule

`default_nettype wire

[design/uart_interrupt_transfer_engine_core.sv]
//------------------------------------------------------------------------------
// uart_interrupt_transfer_engine_core
// Interrupt-driven UART block transfer sequencer, one result per command item.
//
//   port     dir   role
//   i_in     in    command item: func, length, hw_status, rx_byte, clear_mask
//   o_out    out   result item: status, tx/rx moves, clears, enables, flags
//
// One item per cycle while the result side is not stalled; an item passes the
// input register, then the sequencer update into the result register.
// Sequencer state advances as an item moves into the result register, in order.
// A stalled result holds; the input register still takes one more item.
// Synchronous active-low reset returns both directions to ready, clears
// enables and flags, and empties both registers.
//------------------------------------------------------------------------------
`default_nettype none

module uart_interrupt_transfer_engine_core import uite_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    uite_in_if.sink    i_in,
    uite_out_if.source o_out
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result seq_result;
    logic    out_free;
    logic    fire;

    assign out_free   = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.func       <= t_func'(i_in.func);
            r_item.length     <= i_in.length;
            r_item.hw_status  <= i_in.hw_status;
            r_item.rx_byte    <= i_in.rx_byte;
            r_item.clear_mask <= i_in.clear_mask;
        end
    end

    uite_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .o_result (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= seq_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_result.status;
    assign o_out.tx_write      = r_result.tx_write;
    assign o_out.tx_index      = r_result.tx_index;
    assign o_out.rx_store      = r_result.rx_store;
    assign o_out.rx_index      = r_result.rx_index;
    assign o_out.rx_data       = r_result.rx_data;
    assign o_out.clear_pending = r_result.clear_pending;
    assign o_out.control_bits  = r_result.control_bits;
    assign o_out.runtime_flags = r_result.runtime_flags;
    assign o_out.notify        = r_result.notify;

`ifndef SYNTHESIS
    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("item left input register but no result appeared");

    a_status_start_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_item.func != FN_START_SEND && r_item.func != FN_START_RECV)
            |-> (seq_result.status == STAT_OK))
        else $error("non-start item reported a non-ok status");

    a_tx_needs_te: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.tx_write) |-> ((r_result.control_bits & EN_TE) != '0))
        else $error("transmit byte with transmitter off");

    a_rx_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.notify[NT_RECV])
            |-> ((r_result.runtime_flags & (FL_RXC | FL_IDLE)) != '0))
        else $error("receive done without rx complete or idle flag");
`endif

endmodule

`default_nettype wire

[bench/uart_interrupt_transfer_engine_core_tb.sv]
//------------------------------------------------------------------------------
// uart_interrupt_transfer_engine_core_tb
// Self-checking bench for the UART interrupt transfer engine. A short directed
// run covers rejects, busy restarts, send/receive completion, idle abort, line
// errors and kills. It is followed by random send and receive sequences mixed
// with random noise items. Every result is checked against an in-bench
// sequencer model, with random bursts on the sender and stalls on the receiver.
//------------------------------------------------------------------------------
import uite_pkg::*;

class uite_scoreboard;
    t_xfer_state tx_state;
    t_xfer_state rx_state;
    logic [15:0] tx_left;
    logic [15:0] tx_pos;
    logic [15:0] rx_left;
    logic [15:0] rx_pos;
    logic [5:0]  en;
    logic [6:0]  flags;
    t_result     expected_q[$];
    int unsigned errors;
    int unsigned checked;

    function new();
        tx_state = ST_READY;
        rx_state = ST_READY;
        tx_left  = '0;
        tx_pos   = '0;
        rx_left  = '0;
        rx_pos   = '0;
        en       = '0;
        flags    = '0;
        errors   = 0;
        checked  = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Advance the sequencer model by one accepted item and queue its result
    function void note_item(t_item it);
        t_result    r;
        logic [5:0] en_was;
        logic       txe, tc, rxne, idle;
        logic [3:0] errs;
        r      = '0;
        en_was = en;
        txe    = it.hw_status[HW_TXE];
        tc     = it.hw_status[HW_TC];
        rxne   = it.hw_status[HW_RXNE];
        idle   = it.hw_status[HW_IDLE];
        errs   = it.hw_status[7:4];
        case (it.func)
            FN_START_SEND: begin
                if (it.length == 16'd0 || 32'(it.length) > MAX_LEN) begin
                    r.status = STAT_INVALID;
                end else if (tx_state == ST_ONGOING) begin
                    r.status = STAT_BUSY;
                end else begin
                    // first byte goes out right at start
                    r.tx_write = 1'b1;
                    r.tx_index = '0;
                    tx_pos     = 16'd1;
                    tx_left    = it.length - 16'd1;
                    tx_state   = ST_ONGOING;
                    en         = en | EN_TE | EN_TXEIE;
                end
            end
            FN_START_RECV: begin
                if (it.length == 16'd0 || 32'(it.length) > MAX_LEN) begin
                    r.status = STAT_INVALID;
                end else if (rx_state == ST_ONGOING) begin
                    r.status = STAT_BUSY;
                end else begin
                    en       = en | EN_RXNEIE | EN_RE;
                    rx_left  = it.length;
                    rx_pos   = '0;
                    rx_state = ST_ONGOING;
                end
            end
            FN_HW_EVENT: begin
                if ((txe || tc) && (en_was & (EN_TXEIE | EN_TCIE)) != '0) begin
                    if (tx_state == ST_READY) begin
                        r.clear_pending[CLR_TC] = 1'b1;
                        en = en & ~(EN_TCIE | EN_TXEIE);
                    end
                    if (txe && tx_state == ST_ONGOING) begin
                        if (tx_left != '0) begin
                            en         = en & ~EN_TCIE;
                            r.tx_write = 1'b1;
                            r.tx_index = tx_pos;
                            tx_pos     = tx_pos + 16'd1;
                            tx_left    = tx_left - 16'd1;
                        end else begin
                            en       = (en & ~EN_TXEIE) | EN_TCIE;
                            tx_state = ST_COMPLETE;
                        end
                    end
                    if (tc && tx_state == ST_COMPLETE) begin
                        r.clear_pending[CLR_TC] = 1'b1;
                        en    = en & ~(EN_TCIE | EN_TXEIE);
                        flags = flags | FL_TXC;
                        r.notify[NT_SEND] = 1'b1;
                    end
                end
                if (rxne && (en_was & EN_RXNEIE) != '0 && rx_state == ST_ONGOING) begin
                    en = en | EN_IDLEIE;
                    r.clear_pending[CLR_IDLE] = 1'b1;
                    r.rx_store = 1'b1;
                    r.rx_index = rx_pos;
                    r.rx_data  = it.rx_byte;
                    rx_pos     = rx_pos + 16'd1;
                    rx_left    = rx_left - 16'd1;
                    if (rx_left == '0) begin
                        en       = en & ~(EN_IDLEIE | EN_RE);
                        rx_state = ST_COMPLETE;
                        flags    = flags | FL_RXC;
                        r.notify[NT_RECV] = 1'b1;
                    end
                end
                // line idle ends the receive early
                if (idle && (en_was & EN_IDLEIE) != '0 && rx_state == ST_ONGOING) begin
                    en       = en & ~(EN_IDLEIE | EN_RE);
                    rx_state = ST_COMPLETE;
                    flags    = flags | FL_IDLE;
                    r.clear_pending[CLR_IDLE] = 1'b1;
                    r.notify[NT_RECV] = 1'b1;
                end
                if (errs != '0) begin
                    flags = flags | {errs, 3'b000};
                    r.notify[NT_ERR] = 1'b1;
                end
            end
            FN_KILL_SEND: begin
                en       = en & ~(EN_TCIE | EN_TXEIE);
                tx_state = ST_READY;
                tx_left  = '0;
                tx_pos   = '0;
            end
            FN_KILL_RECV: begin
                en       = en & ~EN_RXNEIE;
                rx_state = ST_READY;
                rx_left  = '0;
                rx_pos   = '0;
            end
            FN_CLR_FLAGS: begin
                flags = flags & ~it.clear_mask;
            end
            default: ;
        endcase
        r.control_bits  = en;
        r.runtime_flags = flags;
        expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
        errors++;
        if (errors <= 40)
            $display("MISMATCH result %0d: %s", checked, msg);
    endtask

    task cmp_field(string name, logic [15:0] got_v, logic [15:0] exp_v);
        if (got_v !== exp_v)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got_v, exp_v));
    endtask

    task check_result(t_result got);
        t_result exp_r;
        if (expected_q.size() == 0) begin
            report_mismatch("result with no item outstanding");
        end else begin
            exp_r = expected_q.pop_front();
            cmp_field("status", 16'(got.status), 16'(exp_r.status));
            cmp_field("tx_write", 16'(got.tx_write), 16'(exp_r.tx_write));
            cmp_field("tx_index", got.tx_index, exp_r.tx_index);
            cmp_field("rx_store", 16'(got.rx_store), 16'(exp_r.rx_store));
            cmp_field("rx_index", got.rx_index, exp_r.rx_index);
            cmp_field("rx_data", 16'(got.rx_data), 16'(exp_r.rx_data));
            cmp_field("clear_pending", 16'(got.clear_pending), 16'(exp_r.clear_pending));
            cmp_field("control_bits", 16'(got.control_bits), 16'(exp_r.control_bits));
            cmp_field("runtime_flags", 16'(got.runtime_flags), 16'(exp_r.runtime_flags));
            cmp_field("notify", 16'(got.notify), 16'(exp_r.notify));
        end
        checked++;
    endtask
endclass

module uart_interrupt_transfer_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 450;

    logic i_clk;
    logic i_rst_n;

    uite_in_if  in_if ();
    uite_out_if out_if ();

    uart_interrupt_transfer_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    uite_scoreboard sb = new();
    t_item          stim_q[$];
    int unsigned    results_seen;
    int unsigned    pause_at;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    function automatic t_item mk(t_func f, logic [15:0] len, logic [7:0] hw,
                                 logic [7:0] rxb, logic [6:0] cm);
        t_item it;
        it.func       = f;
        it.length     = len;
        it.hw_status  = hw;
        it.rx_byte    = rxb;
        it.clear_mask = cm;
        return it;
    endfunction

    // Line error bits now and then
    function automatic logic [7:0] err_bits();
        return ($urandom_range(0, 9) == 0) ? {4'($urandom_range(1, 15)), 4'h0} : 8'h00;
    endfunction

    function automatic void build_directed();
        stim_q.push_back(mk(FN_START_SEND, 16'd0, 8'h00, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_START_RECV, 16'd0, 8'h00, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_HW_EVENT, 16'hFFFF, 8'hFF, 8'hFF, 7'h7F));
        stim_q.push_back(mk(FN_CLR_FLAGS, 16'h0000, 8'h00, 8'h00, 7'h7F));
        stim_q.push_back(mk(FN_START_SEND, 16'd2, 8'h00, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_START_SEND, 16'hFFFF, 8'h00, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_HW_EVENT, 16'd0, 8'h01, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_HW_EVENT, 16'd0, 8'h02, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_HW_EVENT, 16'd0, 8'h01, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_HW_EVENT, 16'd0, 8'h02, 8'h00, 7'h00));
        // complete and done in the same item
        stim_q.push_back(mk(FN_START_SEND, 16'd1, 8'h00, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_HW_EVENT, 16'd0, 8'h03, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_START_RECV, 16'hFFFF, 8'h00, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_START_RECV, 16'd3, 8'h00, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_HW_EVENT, 16'd0, 8'h04, 8'hFF, 7'h00));
        stim_q.push_back(mk(FN_HW_EVENT, 16'd0, 8'h04, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_HW_EVENT, 16'd0, 8'h08, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_START_RECV, 16'd1, 8'h00, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_HW_EVENT, 16'd0, 8'hF4, 8'hA5, 7'h00));
        stim_q.push_back(mk(FN_CLR_FLAGS, 16'd0, 8'h00, 8'h00, 7'h2A));
        stim_q.push_back(mk(FN_START_SEND, 16'hFFFF, 8'h00, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_KILL_SEND, 16'd0, 8'h00, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_KILL_RECV, 16'd0, 8'h00, 8'h00, 7'h00));
        stim_q.push_back(mk(FN_CLR_FLAGS, 16'd0, 8'h00, 8'h00, 7'h55));
    endfunction

    function automatic void build_random(int unsigned stop_at);
        int unsigned kind;
        int unsigned steps;
        int unsigned abort_at;
        int unsigned ending;
        logic [15:0] len;
        logic [7:0]  hw;
        while (stim_q.size() < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(9, 65535))
                                                   : 16'($urandom_range(1, 8));
                stim_q.push_back(mk(FN_START_SEND, len, 8'($urandom), 8'($urandom),
                                    7'($urandom)));
                steps = (len > 16'd8) ? $urandom_range(1, 6)
                                      : int'(len) - (($urandom_range(0, 7) == 0) ? 1 : 0);
                for (int i = 0; i < steps; i++) begin
                    hw = 8'h01 | err_bits() | (($urandom_range(0, 3) == 0) ? 8'h04 : 8'h00);
                    stim_q.push_back(mk(FN_HW_EVENT, 16'($urandom), hw, 8'($urandom),
                                        7'($urandom)));
                end
                ending = $urandom_range(0, 7);
                if (ending == 0)
                    stim_q.push_back(mk(FN_KILL_SEND, 16'($urandom), 8'($urandom),
                                        8'($urandom), 7'($urandom)));
                else if (ending > 1)
                    stim_q.push_back(mk(FN_HW_EVENT, 16'($urandom), 8'h02 | err_bits(),
                                        8'($urandom), 7'($urandom)));
            end else if (kind < 8) begin
                len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(7, 65535))
                                                   : 16'($urandom_range(1, 6));
                stim_q.push_back(mk(FN_START_RECV, len, 8'($urandom), 8'($urandom),
                                    7'($urandom)));
                steps    = (len > 16'd6) ? $urandom_range(1, 6) : int'(len);
                abort_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, steps) : steps + 1;
                for (int i = 0; i < steps; i++) begin
                    if (i == abort_at) begin
                        stim_q.push_back(mk(FN_HW_EVENT, 16'($urandom), 8'h08 | err_bits(),
                                            8'($urandom), 7'($urandom)));
                        break;
                    end
                    hw = 8'h04 | err_bits() | 8'($urandom_range(0, 3));
                    stim_q.push_back(mk(FN_HW_EVENT, 16'($urandom), hw, 8'($urandom),
                                        7'($urandom)));
                end
                if ($urandom_range(0, 7) == 0)
                    stim_q.push_back(mk(FN_KILL_RECV, 16'($urandom), 8'($urandom),
                                        8'($urandom), 7'($urandom)));
            end else begin
                steps = $urandom_range(1, 4);
                for (int i = 0; i < steps; i++) begin
                    len = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
                    stim_q.push_back(mk(t_func'($urandom_range(0, 5)), len, 8'($urandom),
                                        8'($urandom), 7'($urandom)));
                end
            end
        end
    endfunction

    task automatic drive_items();
        int unsigned burst;
        int unsigned gap;
        t_item       it;
        burst = $urandom_range(1, 24);
        for (int unsigned idx = 0; idx < stim_q.size(); idx++) begin
            it = stim_q[idx];
            if (idx == pause_at) begin
                // drain everything before going on
                @(negedge i_clk);
                in_if.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            @(negedge i_clk);
            in_if.valid      <= 1'b1;
            in_if.func       <= it.func;
            in_if.length     <= it.length;
            in_if.hw_status  <= it.hw_status;
            in_if.rx_byte    <= it.rx_byte;
            in_if.clear_mask <= it.clear_mask;
            @(posedge i_clk);
            while (!in_if.ready) @(posedge i_clk);
            sb.note_item(it);
            burst--;
            if (burst == 0) begin
                gap = $urandom_range(1, 8);
                @(negedge i_clk);
                in_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
                burst = $urandom_range(1, 40);
            end
        end
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    // Result side: stall pattern rotates through four modes, plus one long hold
    initial begin
        int unsigned cyc;
        bit          held;
        cyc  = 0;
        held = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (!held && results_seen >= 150) begin
                held = 1'b1;
                out_if.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end
            case ((cyc / 50) % 4)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= ($urandom_range(0, 3) != 0);
                2: out_if.ready <= ($urandom_range(0, 3) == 0);
                default: out_if.ready <= cyc[0];
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.status        = t_status'(out_if.status);
            got.tx_write      = out_if.tx_write;
            got.tx_index      = out_if.tx_index;
            got.rx_store      = out_if.rx_store;
            got.rx_index      = out_if.rx_index;
            got.rx_data       = out_if.rx_data;
            got.clear_pending = out_if.clear_pending;
            got.control_bits  = out_if.control_bits;
            got.runtime_flags = out_if.runtime_flags;
            got.notify        = out_if.notify;
            sb.check_result(got);
            results_seen++;
        end
    end

    initial begin
        int unsigned n_directed;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.func       = '0;
        in_if.length     = '0;
        in_if.hw_status  = '0;
        in_if.rx_byte    = '0;
        in_if.clear_mask = '0;
        results_seen     = 0;
        build_directed();
        n_directed = stim_q.size();
        build_random(n_directed + RANDOM_ITEMS);
        pause_at = n_directed + (stim_q.size() - n_directed) * 3 / 4;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        drive_items();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
